FILE: rtl/mpsc_pkg.sv
package mpsc_pkg;

   // Number of motor channels with their own PID state.
   localparam int CHANNELS_DEF = 4;

   // Configuration register indexes.
   localparam logic [1:0] REG_KP          = 2'd0;
   localparam logic [1:0] REG_KI          = 2'd1;
   localparam logic [1:0] REG_KD          = 2'd2;
   localparam logic [1:0] REG_ENCODER_MAX = 2'd3;

   localparam logic signed [15:0] KP_RESET          = 16'sd384;
   localparam logic signed [15:0] KI_RESET          = 16'sd0;
   localparam logic signed [15:0] KD_RESET          = 16'sd0;
   localparam logic [15:0]        ENCODER_MAX_RESET = 16'd280;

   // count * 100 percent in Q8.8
   localparam logic [14:0] SPEED_SCALE = 15'd25600;
   localparam int          DIVIDEND_W  = 30;
   localparam int          DIV_CNT_W   = 5;

   localparam int ERR_W   = 32;
   localparam int INTEG_W = 40;
   localparam int DIFF_W  = 33;
   localparam int MULB_W  = 33;
   localparam int PROD_W  = 49;
   localparam int ACC_W   = 58;
   // ki times the integral is split at this bit
   localparam int INTEG_SPLIT = 20;

   localparam logic signed [ACC_W-1:0] ACC_LIMIT = 58'sd6553600;
   localparam logic signed [15:0]      DUTY_MAX  = 16'sd25600;
   localparam logic signed [15:0]      DUTY_MIN  = -16'sd25600;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_ERR,
      ST_MUL_P,
      ST_MUL_ILO,
      ST_MUL_IHI,
      ST_MUL_D,
      ST_ACC,
      ST_OUT
   } state_type;

endpackage

FILE: rtl/multichannel_pid_speed_controller.sv
// Channel   Ports      Content (lowest bit first)
// req       tdata      encoder_count[15:0], target[31:16]
// req       tuser      channel[1:0]
// rsp       tdata      duty[15:0]
// rsp       tuser      out_channel[1:0], clamped[2]
// csr       we/index   kp, ki, kd, encoder_max (16-bit data)
//
// Each item first runs through the restoring divider (one quotient bit a
// cycle) that scales the count to percent; the sequencer then feeds one
// shared 16x33 multiplier four times, with kp, ki (twice) and kd.
// req_tready is high only while the sequencer is idle; a finished result
// sits in the output register, so the next item is taken while it waits.
// Synchronous reset clears gains to defaults and all channel state to zero.
// Items for a channel at or above CHANNELS are dropped without a result.
module multichannel_pid_speed_controller #(
   parameter int CHANNELS = mpsc_pkg::CHANNELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // encoder_count[15:0], target[31:16]
   input  logic [1:0]  req_tuser,   // channel[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // duty[15:0]
   output logic [2:0]  rsp_tuser,   // out_channel[1:0], clamped[2]
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam int EW = mpsc_pkg::ERR_W;
   localparam int IW = mpsc_pkg::INTEG_W;
   localparam int DW = mpsc_pkg::DIFF_W;
   localparam int BW = mpsc_pkg::MULB_W;
   localparam int PW = mpsc_pkg::PROD_W;
   localparam int AW = mpsc_pkg::ACC_W;
   localparam int QW = mpsc_pkg::DIVIDEND_W;
   localparam int SP = mpsc_pkg::INTEG_SPLIT;
   localparam int CW = mpsc_pkg::DIV_CNT_W;

   localparam logic signed [IW-1:0] INTEG_MAX = {1'b0, {(IW-1){1'b1}}};
   localparam logic signed [IW-1:0] INTEG_MIN = {1'b1, {(IW-1){1'b0}}};

   localparam logic [29:0] SPEED_SCALE_W = {15'd0, mpsc_pkg::SPEED_SCALE};

   mpsc_pkg::state_type state_ff, state_in;

   logic signed [15:0] kp_ff, ki_ff, kd_ff;
   logic [15:0]        encoder_max_ff;

   logic signed [EW-1:0] previous_error_ff [CHANNELS];
   logic signed [IW-1:0] error_integral_ff [CHANNELS];

   logic [1:0]           chan_ff, chan_in;
   logic signed [15:0]   target_ff, target_in;
   logic                 neg_ff, neg_in;
   logic [QW-1:0]        quo_ff, quo_in;
   logic [15:0]          rem_ff, rem_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic signed [EW-1:0] err_ff, err_in;
   logic signed [IW-1:0] integ_ff, integ_in;
   logic signed [DW-1:0] diff_ff, diff_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [AW-1:0] acc_ff, acc_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [15:0]          rsp_duty_ff, rsp_duty_in;
   logic [1:0]           rsp_chan_ff, rsp_chan_in;
   logic                 rsp_clamped_ff, rsp_clamped_in;

   logic                 req_take;
   logic                 chan_ok;
   logic [4:0]           chan_wide;
   logic [CH_IDX_W-1:0]  ch_idx;
   logic [15:0]          divisor;
   logic [16:0]          trial;
   logic                 trial_ge;
   logic signed [EW-1:0] speed;
   logic signed [EW-1:0] err_c;
   logic signed [IW:0]   sum_c;
   logic signed [IW-1:0] integ_c;
   logic signed [15:0]   mul_a;
   logic signed [BW-1:0] mul_b;
   logic signed [AW-1:0] acc_term;
   logic                 out_free;
   logic [15:0]          count_mag;

   assign req_tready = (state_ff == mpsc_pkg::ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign chan_ok    = ({3'b000, req_tuser} < 5'(CHANNELS));
   assign chan_wide  = {3'b000, chan_ff};
   assign ch_idx     = chan_wide[CH_IDX_W-1:0];
   assign divisor    = (encoder_max_ff == 16'd0) ? 16'd1 : encoder_max_ff;
   assign trial      = {rem_ff, quo_ff[QW-1]};
   assign trial_ge   = (trial >= {1'b0, divisor});
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign count_mag  = req_tdata[15] ? (16'd0 - req_tdata[15:0]) : req_tdata[15:0];

   // Error and saturated integral
   always_comb begin
      speed   = neg_ff ? -$signed({2'b00, quo_ff}) : $signed({2'b00, quo_ff});
      err_c   = {{(EW-16){target_ff[15]}}, target_ff} - speed;
      sum_c   = {error_integral_ff[ch_idx][IW-1], error_integral_ff[ch_idx]}
                + {{(IW+1-EW){err_c[EW-1]}}, err_c};
      if (sum_c[IW] != sum_c[IW-1]) begin
         integ_c = sum_c[IW] ? INTEG_MIN : INTEG_MAX;
      end else begin
         integ_c = sum_c[IW-1:0];
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mpsc_pkg::ST_IDLE: begin
            if (req_take && chan_ok) begin
               state_in = mpsc_pkg::ST_DIV;
            end
         end
         mpsc_pkg::ST_DIV: begin
            if (cnt_ff == CW'(QW - 1)) begin
               state_in = mpsc_pkg::ST_ERR;
            end
         end
         mpsc_pkg::ST_ERR:     state_in = mpsc_pkg::ST_MUL_P;
         mpsc_pkg::ST_MUL_P:   state_in = mpsc_pkg::ST_MUL_ILO;
         mpsc_pkg::ST_MUL_ILO: state_in = mpsc_pkg::ST_MUL_IHI;
         mpsc_pkg::ST_MUL_IHI: state_in = mpsc_pkg::ST_MUL_D;
         mpsc_pkg::ST_MUL_D:   state_in = mpsc_pkg::ST_ACC;
         mpsc_pkg::ST_ACC:     state_in = mpsc_pkg::ST_OUT;
         mpsc_pkg::ST_OUT: begin
            if (out_free) begin
               state_in = mpsc_pkg::ST_IDLE;
            end
         end
         default: state_in = mpsc_pkg::ST_IDLE;
      endcase
   end

   // Shared multiplier operands
   always_comb begin
      mul_a = kp_ff;
      mul_b = {err_ff[EW-1], err_ff};
      unique case (state_ff)
         mpsc_pkg::ST_MUL_ILO: begin
            mul_a = ki_ff;
            mul_b = {{(BW-SP){1'b0}}, integ_ff[SP-1:0]};
         end
         mpsc_pkg::ST_MUL_IHI: begin
            mul_a = ki_ff;
            mul_b = {{(BW-(IW-SP)){integ_ff[IW-1]}}, integ_ff[IW-1:SP]};
         end
         mpsc_pkg::ST_MUL_D: begin
            mul_a = kd_ff;
            mul_b = diff_ff;
         end
         default: begin
            mul_a = kp_ff;
            mul_b = {err_ff[EW-1], err_ff};
         end
      endcase
   end

   // Datapath and output register
   always_comb begin
      chan_in        = chan_ff;
      target_in      = target_ff;
      neg_in         = neg_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      cnt_in         = cnt_ff;
      err_in         = err_ff;
      integ_in       = integ_ff;
      diff_in        = diff_ff;
      prod_in        = PW'(mul_a * mul_b);
      acc_in         = acc_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_duty_in    = rsp_duty_ff;
      rsp_chan_in    = rsp_chan_ff;
      rsp_clamped_in = rsp_clamped_ff;

      // the high integral product enters shifted by the split point
      if (state_ff == mpsc_pkg::ST_MUL_D) begin
         acc_term = {prod_ff[AW-SP-1:0], {SP{1'b0}}};
      end else begin
         acc_term = {{(AW-PW){prod_ff[PW-1]}}, prod_ff};
      end

      unique case (state_ff)
         mpsc_pkg::ST_IDLE: begin
            if (req_take) begin
               chan_in   = req_tuser;
               target_in = req_tdata[31:16];
               neg_in    = req_tdata[15];
               quo_in    = QW'(count_mag * SPEED_SCALE_W);
               rem_in    = 16'd0;
               cnt_in    = '0;
            end
         end
         mpsc_pkg::ST_DIV: begin
            rem_in = trial_ge ? 16'(trial - {1'b0, divisor}) : trial[15:0];
            quo_in = {quo_ff[QW-2:0], trial_ge};
            cnt_in = cnt_ff + 1'b1;
         end
         mpsc_pkg::ST_ERR: begin
            err_in   = err_c;
            integ_in = integ_c;
            diff_in  = {err_c[EW-1], err_c}
                       - {previous_error_ff[ch_idx][EW-1], previous_error_ff[ch_idx]};
         end
         mpsc_pkg::ST_MUL_P: begin
            acc_in = '0;
         end
         mpsc_pkg::ST_MUL_ILO, mpsc_pkg::ST_MUL_IHI, mpsc_pkg::ST_MUL_D,
         mpsc_pkg::ST_ACC: begin
            acc_in = acc_ff + acc_term;
         end
         mpsc_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_chan_in  = chan_ff;
               if (acc_ff > mpsc_pkg::ACC_LIMIT) begin
                  rsp_duty_in    = mpsc_pkg::DUTY_MAX;
                  rsp_clamped_in = 1'b1;
               end else if (acc_ff < -mpsc_pkg::ACC_LIMIT) begin
                  rsp_duty_in    = mpsc_pkg::DUTY_MIN;
                  rsp_clamped_in = 1'b1;
               end else begin
                  rsp_duty_in    = acc_ff[23:8];
                  rsp_clamped_in = 1'b0;
               end
            end
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= mpsc_pkg::ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         kp_ff          <= mpsc_pkg::KP_RESET;
         ki_ff          <= mpsc_pkg::KI_RESET;
         kd_ff          <= mpsc_pkg::KD_RESET;
         encoder_max_ff <= mpsc_pkg::ENCODER_MAX_RESET;
         for (int i = 0; i < CHANNELS; i++) begin
            previous_error_ff[i] <= '0;
            error_integral_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               mpsc_pkg::REG_KP:          kp_ff          <= csr_wdata;
               mpsc_pkg::REG_KI:          ki_ff          <= csr_wdata;
               mpsc_pkg::REG_KD:          kd_ff          <= csr_wdata;
               mpsc_pkg::REG_ENCODER_MAX: encoder_max_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (state_ff == mpsc_pkg::ST_ERR) begin
            previous_error_ff[ch_idx] <= err_c;
            error_integral_ff[ch_idx] <= integ_c;
         end
      end
   end

   always_ff @(posedge clock) begin
      chan_ff        <= chan_in;
      target_ff      <= target_in;
      neg_ff         <= neg_in;
      quo_ff         <= quo_in;
      rem_ff         <= rem_in;
      cnt_ff         <= cnt_in;
      err_ff         <= err_in;
      integ_ff       <= integ_in;
      diff_ff        <= diff_in;
      prod_ff        <= prod_in;
      acc_ff         <= acc_in;
      rsp_duty_ff    <= rsp_duty_in;
      rsp_chan_ff    <= rsp_chan_in;
      rsp_clamped_ff <= rsp_clamped_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_duty_ff;
   assign rsp_tuser  = {rsp_clamped_ff, rsp_chan_ff};

endmodule
